// ===== design/matrix_vector_multiply_accumulate_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the matrix-vector multiply-accumulate unit
// Shared property wrappers; every user module has clk_i and rst_ni.
// ---------------------------------------------------------------------------
`ifndef MATRIX_VECTOR_MULTIPLY_ACCUMULATE_UNIT_DEFINES_SVH
`define MATRIX_VECTOR_MULTIPLY_ACCUMULATE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MVMAC_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MVMAC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/mvmac_pkg.sv =====
// ---------------------------------------------------------------------------
// mvmac_pkg
// Types and fixed constants shared by the multiply-accumulate unit modules.
// ---------------------------------------------------------------------------
package mvmac_pkg;

  localparam int unsigned DATA_W      = 16;  // Q8.8 data width
  localparam int unsigned FRAC_W      = 8;
  localparam int unsigned SUM_W       = 40;  // Q24.16 accumulator, wraps
  localparam int unsigned ADDR_W      = 12;  // holds any column index in range
  localparam int unsigned ROW_OUT_W   = 12;
  localparam int unsigned ROW_CNT_W   = 13;
  localparam int unsigned COL_CNT_W   = 9;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_COUNT    = 2'd0,
    REG_COLUMN_COUNT = 2'd1,
    REG_ALPHA_SCALE  = 2'd2,
    REG_BETA_SCALE   = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_MAC  = 1'b1
  } cmd_e;

  // One classified beat, handed from the front end to the datapath.
  typedef struct packed {
    cmd_e                    cmd;
    logic [ADDR_W-1:0]       addr;
    logic [DATA_W-1:0]       data;
    logic [DATA_W-1:0]       prior_y;
    logic                    row_end;
    logic [ROW_OUT_W-1:0]    row_num;
    logic                    last_row;
  } op_t;

endpackage

// ===== design/matrix_vector_multiply_accumulate_unit.sv =====
// ---------------------------------------------------------------------------
// matrix_vector_multiply_accumulate_unit
// Row-major y = alpha*A*x + beta*y in signed Q8.8 fixed point.
// ---------------------------------------------------------------------------
//
//  Channel  | Direction | Content
//  ---------+-----------+-------------------------------------------------
//  s_axis   | in        | load or matrix beats (tuser = command)
//  m_axis   | out       | one y result per finished row (tlast = last row)
//  cfg      | in        | register writes: row/column counts, alpha, beta
//
// The unit sustains one input beat per clock while m_axis is not stalled: every
// beat is one queue entry and one pass through the datapath, which issues one
// memory access and one multiply per cycle. After its last matrix beat sits in
// the queue, a row result passes through the fetch, product, accumulate, scale
// and round registers in turn before it appears on m_axis.
// Reset clears positions, the accumulator and all valid flags; the x vector
// memory is not cleared and must be loaded before it is used.
// A stall on m_axis freezes the datapath; the four-entry queue keeps taking
// beats until it fills, then s_axis_tready_o drops.
//
// The front end classifies each beat: a load beat gets the next x slot, a
// matrix beat gets the current column and, on a row's last column, the row
// number and the last-row flag. The datapath keeps the x memory, multiplies
// each matrix element by its x element and accumulates a 40-bit wrapping sum.
// At the row's end the total is scaled by alpha, beta*prior_y is added, and
// the Q34.24 value is rounded half up to Q8.8 and clipped to 16 bits.
// ---------------------------------------------------------------------------
module matrix_vector_multiply_accumulate_unit #(
  parameter int unsigned MAX_COLUMNS = 256,
  parameter int unsigned MAX_ROWS    = 4096
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Input stream
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  logic [31:0]                          s_axis_tdata_i,  // data_value, prior_y
  input  logic                                 s_axis_tuser_i,  // command
  // Result stream
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  output logic [31:0]                          m_axis_tdata_o,  // y_value, row_number
  output logic                                 m_axis_tuser_o,  // saturated
  output logic                                 m_axis_tlast_o,  // last_row
  // Configuration write port
  input  logic                                 cfg_we_i,
  input  logic [mvmac_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mvmac_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_COLUMNS);
  localparam int unsigned RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned DW = mvmac_pkg::DATA_W;

  logic [mvmac_pkg::ROW_CNT_W-1:0] row_count_q;
  logic [mvmac_pkg::COL_CNT_W-1:0] column_count_q;
  logic signed [DW-1:0]            alpha_q, beta_q;

  logic [31:0] col_wide, row_wide;
  logic [AW:0] col_limit;
  logic [RW:0] row_limit;

  logic           push, pop, q_full, q_empty;
  mvmac_pkg::op_t push_op, head_op;

  logic [DW-1:0]                    y_value;
  logic [mvmac_pkg::ROW_OUT_W-1:0]  row_number;

  // Configuration registers; the user must write them only while the unit is idle (not enforced here).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q    <= mvmac_pkg::ROW_CNT_W'(1);
      column_count_q <= mvmac_pkg::COL_CNT_W'(1);
      alpha_q        <= DW'(256);
      beta_q         <= '0;
    end else if (cfg_we_i) begin
      unique case (mvmac_pkg::cfg_reg_e'(cfg_index_i))
        mvmac_pkg::REG_ROW_COUNT:    row_count_q    <= cfg_data_i[mvmac_pkg::ROW_CNT_W-1:0];
        mvmac_pkg::REG_COLUMN_COUNT: column_count_q <= cfg_data_i[mvmac_pkg::COL_CNT_W-1:0];
        mvmac_pkg::REG_ALPHA_SCALE:  alpha_q        <= cfg_data_i;
        mvmac_pkg::REG_BETA_SCALE:   beta_q         <= cfg_data_i;
      endcase
    end
  end

  // Effective sizes: zero acts as one, anything above the build limit is clamped.
  always_comb begin
    col_wide = 32'(column_count_q);
    if (col_wide == 32'd0) begin
      col_wide = 32'd1;
    end else if (col_wide > 32'(MAX_COLUMNS)) begin
      col_wide = 32'(MAX_COLUMNS);
    end
    row_wide = 32'(row_count_q);
    if (row_wide == 32'd0) begin
      row_wide = 32'd1;
    end else if (row_wide > 32'(MAX_ROWS)) begin
      row_wide = 32'(MAX_ROWS);
    end
  end

  assign col_limit = col_wide[AW:0];
  assign row_limit = row_wide[RW:0];

  mvmac_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_cmd_i     (s_axis_tuser_i),
    .in_data_i    (s_axis_tdata_i[DW-1:0]),
    .in_prior_y_i (s_axis_tdata_i[2*DW-1:DW]),
    .in_ready_o   (s_axis_tready_o),
    .col_limit_i  (col_limit),
    .row_limit_i  (row_limit),
    .q_full_i     (q_full),
    .push_o       (push),
    .op_o         (push_op)
  );

  mvmac_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (push_op),
    .pop_i   (pop),
    .op_o    (head_op),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  mvmac_back #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .op_i        (head_op),
    .pop_o       (pop),
    .alpha_i     (alpha_q),
    .beta_i      (beta_q),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .y_o         (y_value),
    .row_o       (row_number),
    .sat_o       (m_axis_tuser_o),
    .last_o      (m_axis_tlast_o)
  );

  // Result beat: y_value in the low half, row_number above it, zero fill on top.
  assign m_axis_tdata_o = {{(32-DW-mvmac_pkg::ROW_OUT_W){1'b0}}, row_number, y_value};

endmodule

// ===== design/mvmac_front.sv =====
// ---------------------------------------------------------------------------
// mvmac_front
// Accepts input beats, tracks load, column and row positions, and pushes
// classified operations into the queue.
// ---------------------------------------------------------------------------
module mvmac_front #(
  parameter int unsigned MAX_COLUMNS = 256,
  parameter int unsigned MAX_ROWS    = 4096
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_cmd_i,
  input  logic [mvmac_pkg::DATA_W-1:0]       in_data_i,
  input  logic [mvmac_pkg::DATA_W-1:0]       in_prior_y_i,
  output logic                               in_ready_o,
  input  logic [$clog2(MAX_COLUMNS):0]       col_limit_i,
  input  logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1):0] row_limit_i,
  input  logic                               q_full_i,
  output logic                               push_o,
  output mvmac_pkg::op_t                     op_o
);

  localparam int unsigned AW = $clog2(MAX_COLUMNS);
  localparam int unsigned RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [AW-1:0] load_q, col_q;
  logic [RW-1:0] row_q;
  logic [AW:0]   load_next, col_next;
  logic [RW:0]   row_next;
  logic          load_wrap, row_end, last_row, accept, is_load;
  logic [RW+mvmac_pkg::ROW_OUT_W-1:0] row_ext;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign is_load    = (mvmac_pkg::cmd_e'(in_cmd_i) == mvmac_pkg::CMD_LOAD);

  assign load_next = {1'b0, load_q} + (AW+1)'(1);
  assign col_next  = {1'b0, col_q} + (AW+1)'(1);
  assign row_next  = {1'b0, row_q} + (RW+1)'(1);
  assign load_wrap = (load_next >= col_limit_i);
  assign row_end   = (col_next >= col_limit_i);
  assign last_row  = (row_next >= row_limit_i);
  assign row_ext   = {{mvmac_pkg::ROW_OUT_W{1'b0}}, row_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q <= '0;
      col_q  <= '0;
      row_q  <= '0;
    end else if (accept) begin
      if (is_load) begin
        load_q <= load_wrap ? '0 : load_next[AW-1:0];
      end else if (row_end) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_next[RW-1:0];
      end else begin
        col_q <= col_next[AW-1:0];
      end
    end
  end

  always_comb begin
    op_o.cmd      = mvmac_pkg::cmd_e'(in_cmd_i);
    op_o.addr     = is_load ? mvmac_pkg::ADDR_W'(load_q) : mvmac_pkg::ADDR_W'(col_q);
    op_o.data     = in_data_i;
    op_o.prior_y  = in_prior_y_i;
    op_o.row_end  = row_end && !is_load;
    op_o.row_num  = row_ext[mvmac_pkg::ROW_OUT_W-1:0];
    op_o.last_row = last_row;
  end

  assign push_o = accept;

endmodule

// ===== design/mvmac_fifo.sv =====
// ---------------------------------------------------------------------------
// mvmac_fifo
// Short operation queue that decouples the front end from the datapath.
// ---------------------------------------------------------------------------
`include "matrix_vector_multiply_accumulate_unit_defines.svh"

module mvmac_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mvmac_pkg::op_t op_i,
  input  logic           pop_i,
  output mvmac_pkg::op_t op_o,
  output logic           full_o,
  output logic           empty_o
);

  localparam logic [mvmac_pkg::QPTR_W:0] DEPTH_CNT =
    (mvmac_pkg::QPTR_W+1)'(mvmac_pkg::QUEUE_DEPTH);
  localparam logic [mvmac_pkg::QPTR_W:0] ONE_CNT = (mvmac_pkg::QPTR_W+1)'(1);

  mvmac_pkg::op_t slots_q [mvmac_pkg::QUEUE_DEPTH];
  logic [mvmac_pkg::QPTR_W-1:0] wr_q, rd_q;
  logic [mvmac_pkg::QPTR_W:0]   count_q;
  logic [mvmac_pkg::QPTR_W:0]   count_inc;

  assign full_o    = (count_q == (mvmac_pkg::QPTR_W+1)'(mvmac_pkg::QUEUE_DEPTH));
  assign empty_o   = (count_q == '0);
  assign op_o      = slots_q[rd_q];
  assign count_inc = count_q + ONE_CNT;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + mvmac_pkg::QPTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + mvmac_pkg::QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (mvmac_pkg::QPTR_W+1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (mvmac_pkg::QPTR_W+1)'(1);
      end
    end
  end

  `MVMAC_ASSERT(a_count_bound, 1'b1, count_q <= DEPTH_CNT, "queue count above depth")
  `MVMAC_ASSERT(a_pop_nonempty, pop_i, !empty_o, "pop from empty queue")
  `MVMAC_ASSERT_NEXT(a_count_up, push_i && !pop_i, count_q == $past(count_inc), "no growth on push")

endmodule

// ===== design/mvmac_back.sv =====
// ---------------------------------------------------------------------------
// mvmac_back
// Datapath: x vector memory, multiply-accumulate pipeline and per-row
// alpha/beta scaling with rounding and saturation.
// ---------------------------------------------------------------------------
`include "matrix_vector_multiply_accumulate_unit_defines.svh"

module mvmac_back #(
  parameter int unsigned MAX_COLUMNS = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                q_empty_i,
  input  mvmac_pkg::op_t                      op_i,
  output logic                                pop_o,
  input  logic signed [mvmac_pkg::DATA_W-1:0] alpha_i,
  input  logic signed [mvmac_pkg::DATA_W-1:0] beta_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [mvmac_pkg::DATA_W-1:0]        y_o,
  output logic [mvmac_pkg::ROW_OUT_W-1:0]     row_o,
  output logic                                sat_o,
  output logic                                last_o
);

  localparam int unsigned AW  = $clog2(MAX_COLUMNS);
  localparam int unsigned DW  = mvmac_pkg::DATA_W;
  localparam int unsigned SW  = mvmac_pkg::SUM_W;
  localparam int unsigned PW  = 2 * DW;
  localparam int unsigned AS  = DW + SW;
  localparam int unsigned TW  = AS + 2;
  localparam int unsigned SH  = 2 * mvmac_pkg::FRAC_W;
  localparam int unsigned QW  = TW - SH;
  localparam int unsigned RNW = mvmac_pkg::ROW_OUT_W;

  logic adv, pop, pop_load, pop_mac;

  logic [DW-1:0] vec_mem [MAX_COLUMNS];

  // Stage 1: operand fetch
  logic                 s1_valid_q, s1_end_q, s1_last_q;
  logic signed [DW-1:0] s1_a_q, s1_x_q, s1_py_q;
  logic [RNW-1:0]       s1_row_q;
  // Stage 2: product
  logic                 s2_valid_q, s2_end_q, s2_last_q;
  logic signed [PW-1:0] s2_prod_q;
  logic signed [DW-1:0] s2_py_q;
  logic [RNW-1:0]       s2_row_q;
  // Stage 3: accumulate, row total captured on the last column
  logic [SW-1:0]        sum_q, acc_sum;
  logic                 s3_valid_q, s3_last_q;
  logic signed [SW-1:0] s3_sum_q;
  logic signed [DW-1:0] s3_py_q;
  logic [RNW-1:0]       s3_row_q;
  // Stage 4: scaling products
  logic                 s4_valid_q, s4_last_q;
  logic signed [AS-1:0] s4_asum_q;
  logic signed [PW-1:0] s4_bpy_q;
  logic [RNW-1:0]       s4_row_q;
  // Output register
  logic                 out_valid_q, sat_q, last_q;
  logic [DW-1:0]        y_q;
  logic [RNW-1:0]       row_q;

  logic [TW-1:0] total;
  logic [QW-1:0] rounded;
  logic          ovf_pos, ovf_neg;

  // The whole pipeline moves together whenever the output slot can take data.
  assign adv      = !out_valid_q || out_ready_i;
  assign pop      = adv && !q_empty_i;
  assign pop_load = pop && (op_i.cmd == mvmac_pkg::CMD_LOAD);
  assign pop_mac  = pop && (op_i.cmd == mvmac_pkg::CMD_MAC);
  assign pop_o    = pop;

  always_ff @(posedge clk_i) begin
    if (pop_load) begin
      vec_mem[op_i.addr[AW-1:0]] <= op_i.data;
    end
    if (pop_mac) begin
      s1_x_q <= vec_mem[op_i.addr[AW-1:0]];
    end
  end

  assign acc_sum = sum_q + {{(SW-PW){s2_prod_q[PW-1]}}, s2_prod_q};

  assign total = {{(TW-AS){s4_asum_q[AS-1]}}, s4_asum_q}
               + {{(TW-PW-mvmac_pkg::FRAC_W){s4_bpy_q[PW-1]}}, s4_bpy_q,
                  {mvmac_pkg::FRAC_W{1'b0}}}
               + (TW'(1) << (SH - 1));
  assign rounded = total[TW-1:SH];
  assign ovf_pos = !rounded[QW-1] && (|rounded[QW-2:DW-1]);
  assign ovf_neg = rounded[QW-1] && !(&rounded[QW-2:DW-1]);

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_a_q    <= op_i.data;
      s1_py_q   <= op_i.prior_y;
      s1_end_q  <= op_i.row_end;
      s1_row_q  <= op_i.row_num;
      s1_last_q <= op_i.last_row;

      s2_prod_q <= s1_a_q * s1_x_q;
      s2_py_q   <= s1_py_q;
      s2_end_q  <= s1_end_q;
      s2_row_q  <= s1_row_q;
      s2_last_q <= s1_last_q;

      s3_sum_q  <= acc_sum;
      s3_py_q   <= s2_py_q;
      s3_row_q  <= s2_row_q;
      s3_last_q <= s2_last_q;

      s4_asum_q <= alpha_i * s3_sum_q;
      s4_bpy_q  <= beta_i * s3_py_q;
      s4_row_q  <= s3_row_q;
      s4_last_q <= s3_last_q;

      if (ovf_pos) begin
        y_q <= {1'b0, {(DW-1){1'b1}}};
      end else if (ovf_neg) begin
        y_q <= {1'b1, {(DW-1){1'b0}}};
      end else begin
        y_q <= rounded[DW-1:0];
      end
      sat_q  <= ovf_pos || ovf_neg;
      row_q  <= s4_row_q;
      last_q <= s4_last_q;
    end
  end

  // Control state and the accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      sum_q       <= '0;
    end else if (adv) begin
      s1_valid_q  <= pop_mac;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q && s2_end_q;
      s4_valid_q  <= s3_valid_q;
      out_valid_q <= s4_valid_q;
      if (s2_valid_q) begin
        sum_q <= s2_end_q ? '0 : acc_sum;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign y_o         = y_q;
  assign row_o       = row_q;
  assign sat_o       = sat_q;
  assign last_o      = last_q;

  `MVMAC_ASSERT_NEXT(a_hold_on_stall, !adv, $stable(s1_valid_q) && $stable(s2_valid_q) && $stable(s3_valid_q) && $stable(s4_valid_q) && $stable(sum_q), "pipeline moved while output stalled")
  `MVMAC_ASSERT_NEXT(a_sum_cleared, adv && s2_valid_q && s2_end_q, sum_q == '0, "accumulator not cleared after row end")
  `MVMAC_ASSERT(a_out_from_scale, $rose(out_valid_q), $past(s4_valid_q), "result without a scaled row total")

endmodule
